// ===== rtl/nlcc_pkg.sv =====
`timescale 1ns / 1ps

package nlcc_pkg;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic REG_PER_LINE_MODE = 1'b0;
	localparam logic REG_VERIFY_ENABLE = 1'b1;

	localparam logic [1:0] VERDICT_UNCHECKED = 2'd0;
	localparam logic [1:0] VERDICT_MATCH     = 2'd1;
	localparam logic [1:0] VERDICT_MISMATCH  = 2'd2;
	localparam logic [1:0] VERDICT_MISSING   = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_STAR   = 2'd1,
		PH_DIGIT1 = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [1:0] verdict;
	} result_t;

	typedef struct packed {
		logic per_line_mode;
		logic verify_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] running_sum;
		logic [7:0] parsed_value;
		phase_t     capture_phase;
		logic [7:0] digit_xor;
		logic       reported_flag;
	} state_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.is_hex = 1'b1;
		h.nibble = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			h.nibble = 4'(b - 8'h30);
		end else if (b inside {[8'h61:8'h66]}) begin
			h.nibble = 4'(b - 8'h61 + 8'd10);
		end else if (b inside {[8'h41:8'h46]}) begin
			h.nibble = 4'(b - 8'h41 + 8'd10);
		end else begin
			h.is_hex = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== rtl/nlcc_step.sv =====
`timescale 1ns / 1ps

module nlcc_step (
	input  nlcc_pkg::cfg_t    cfg,
	input  nlcc_pkg::state_t  cur,
	input  nlcc_pkg::item_t   item,
	output nlcc_pkg::state_t  nxt,
	output logic              report,
	output nlcc_pkg::result_t res
);

	nlcc_pkg::hex_t hx;
	logic           printable;

	assign hx = nlcc_pkg::hex_value(item.data_byte);
	assign printable = (item.data_byte >= nlcc_pkg::CH_SPACE)
		&& (item.data_byte <= nlcc_pkg::CH_TILDE);

	// report built from the current state
	always_comb begin
		res.computed_sum = cur.running_sum;
		res.received_sum = 8'd0;
		res.verdict      = nlcc_pkg::VERDICT_UNCHECKED;
		if (cfg.verify_enable) begin
			if (cur.capture_phase == nlcc_pkg::PH_DONE) begin
				res.computed_sum = cur.running_sum ^ nlcc_pkg::CH_STAR ^ cur.digit_xor;
				res.received_sum = cur.parsed_value;
				res.verdict = (res.computed_sum == cur.parsed_value)
					? nlcc_pkg::VERDICT_MATCH : nlcc_pkg::VERDICT_MISMATCH;
			end else begin
				res.verdict = nlcc_pkg::VERDICT_MISSING;
			end
		end
	end

	always_comb begin
		nxt    = cur;
		report = 1'b0;
		if (item.stream_end) begin
			report = !cur.reported_flag;
			nxt    = '0;
		end else if (item.data_byte == nlcc_pkg::CH_NL) begin
			nxt.reported_flag = 1'b0;
			if (cfg.per_line_mode) begin
				report            = 1'b1;
				nxt.reported_flag = 1'b1;
				nxt.running_sum   = 8'd0;
				nxt.capture_phase = nlcc_pkg::PH_IDLE;
			end
		end else if (printable) begin
			nxt.reported_flag = 1'b0;
			nxt.running_sum   = cur.running_sum ^ item.data_byte;
			if (cfg.verify_enable) begin
				if (item.data_byte == nlcc_pkg::CH_STAR) begin
					nxt.capture_phase = nlcc_pkg::PH_STAR;
				end else begin
					case (cur.capture_phase)
						nlcc_pkg::PH_STAR: begin
							if (hx.is_hex) begin
								nxt.digit_xor     = item.data_byte;
								nxt.parsed_value  = {hx.nibble, 4'd0};
								nxt.capture_phase = nlcc_pkg::PH_DIGIT1;
							end else begin
								nxt.capture_phase = nlcc_pkg::PH_IDLE;
							end
						end
						nlcc_pkg::PH_DIGIT1: begin
							if (hx.is_hex) begin
								nxt.digit_xor     = cur.digit_xor ^ item.data_byte;
								nxt.parsed_value  = {cur.parsed_value[7:4], hx.nibble};
								nxt.capture_phase = nlcc_pkg::PH_DONE;
							end else begin
								nxt.capture_phase = nlcc_pkg::PH_IDLE;
							end
						end
						nlcc_pkg::PH_DONE: begin
							nxt.capture_phase = nlcc_pkg::PH_IDLE;
						end
						default: begin
							nxt.capture_phase = cur.capture_phase;
						end
					endcase
				end
			end
		end
	end

endmodule

// ===== rtl/nmea_line_checksum_checker.sv =====
`timescale 1ns / 1ps

// nmea line checksum checker
// item channel: one byte beat per cycle (data_byte, stream_end) on item_valid/item_ready
// result channel: report beats (computed_sum, received_sum, verdict) on result_valid/result_ready
// config: cfg_we writes cfg_data to register cfg_index (0 per_line_mode, 1 verify_enable)
// a beat is taken into an input register, then the checksum state and the report
// are worked out combinationally from it and the report lands in the result register
// a byte's report thus passes the input register and then the result register, and a
// stalled receiver can hold the byte in the input register before its report is valid
// throughput: one byte per cycle while the receiver takes reports
// bytes that give no report still pass through the result stage, so a stalled
// receiver holds the input register and item_ready drops until result_ready
// returns; nothing is lost or repeated
// reset clears the checksum state, empties both stages and sets both config bits to
// 1; the user writes config only while the block is idle, which the block does not enforce
module nmea_line_checksum_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  nlcc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output nlcc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic              cfg_data
);

	nlcc_pkg::cfg_t    cfg_q;
	nlcc_pkg::state_t  state_q;
	nlcc_pkg::state_t  state_nxt;
	nlcc_pkg::item_t   item_s1;
	logic              valid_s1;
	nlcc_pkg::result_t res_nxt;
	nlcc_pkg::result_t result_q;
	logic              result_valid_q;
	logic              report;
	logic              advance;

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	nlcc_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.report (report),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.per_line_mode <= 1'b1;
			cfg_q.verify_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				nlcc_pkg::REG_PER_LINE_MODE: cfg_q.per_line_mode <= cfg_data;
				nlcc_pkg::REG_VERIFY_ENABLE: cfg_q.verify_enable <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= report;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report) begin
			result_q <= res_nxt;
		end
	end

endmodule
